[rtl/core/assert_macros.svh]
// Assertion macros used by the top level of the motor mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a rising clk edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/qmms_pkg.sv]
// Package of the quad motor mixer: payload types, config codes, reset values, saturation.
package qmms_pkg;

    localparam int MOTORS    = 4;
    localparam int SUM_W     = 18;
    localparam int SPEED_W   = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    typedef logic signed [SUM_W-1:0] qmms_sum_t;

    localparam qmms_sum_t SUM_MAX = 18'sh1FFFF;
    localparam qmms_sum_t SUM_MIN = 18'sh20000;

    // Register reset values
    localparam logic [9:0]  SLEW_STEP_RST    = 10'd15;
    localparam logic [11:0] YAW_LIMIT_RST    = 12'd100;
    localparam logic [9:0]  CUT_THROTTLE_RST = 10'd50;
    localparam logic [11:0] SPEED_MAX_RST    = 12'd1000;
    localparam logic [7:0]  FAULT_STEP_RST   = 8'd2;

    // Flight modes; codes 4..7 hold the speeds
    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_NORMAL     = 3'd1,
        MODE_FIX_HEIGHT = 3'd2,
        MODE_FAULT      = 3'd3
    } qmms_mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLEW_STEP    = 3'd0,
        CFG_YAW_LIMIT    = 3'd1,
        CFG_CUT_THROTTLE = 3'd2,
        CFG_SPEED_MAX    = 3'd3,
        CFG_FAULT_STEP   = 3'd4
    } qmms_cfg_idx_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic [9:0]         throttle;
        logic signed [15:0] pitch_term;
        logic signed [15:0] roll_term;
        logic signed [15:0] yaw_term;
        logic signed [15:0] altitude_term;
    } qmms_item_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_front_left;
        logic [SPEED_W-1:0] speed_rear_left;
        logic [SPEED_W-1:0] speed_front_right;
        logic [SPEED_W-1:0] speed_rear_right;
        logic               landed_flag;
    } qmms_result_t;

    typedef struct packed {
        logic [9:0]  slew_step;
        logic [11:0] yaw_limit;
        logic [9:0]  cut_throttle;
        logic [11:0] speed_max;
        logic [7:0]  fault_step;
    } qmms_cfg_t;

    // Saturate a 20-bit signed sum to the 18-bit range
    function automatic qmms_sum_t sat_sum(input logic signed [19:0] v);
        qmms_sum_t r;
        if (v > 20'sd131071)
        begin
            r = SUM_MAX;
        end
        else if (v < -20'sd131072)
        begin
            r = SUM_MIN;
        end
        else
        begin
            r = $signed(v[SUM_W-1:0]);
        end
        return r;
    endfunction

endpackage

[rtl/core/qmms_mixer.sv]
// X-frame mixer: turns mode, throttle and controller terms into four motor targets.
module qmms_mixer (
    input  qmms_pkg::qmms_item_t              item,
    input  qmms_pkg::qmms_cfg_t               cfg,
    input  logic [qmms_pkg::SPEED_W-1:0]      motor_speed [qmms_pkg::MOTORS],
    output qmms_pkg::qmms_sum_t               target      [qmms_pkg::MOTORS],
    output logic                              landed
);
    import qmms_pkg::*;

    logic signed [16:0] yaw_ext;
    logic signed [16:0] lim_pos;
    logic signed [16:0] lim_neg;
    logic signed [16:0] yaw_c;
    logic signed [19:0] thr20;
    logic signed [19:0] p20;
    logic signed [19:0] r20;
    logic signed [19:0] y20;
    logic signed [19:0] a20;
    logic               all_low;

    // Yaw clamp to +-yaw_limit
    always_comb
    begin
        yaw_ext = 17'(item.yaw_term);
        lim_pos = $signed({5'b0, cfg.yaw_limit});
        lim_neg = -lim_pos;
        if (yaw_ext > lim_pos)
        begin
            yaw_c = lim_pos;
        end
        else if (yaw_ext < lim_neg)
        begin
            yaw_c = lim_neg;
        end
        else
        begin
            yaw_c = yaw_ext;
        end
    end

    // Operands widened for the mixer sums
    always_comb
    begin
        thr20 = 20'($signed({1'b0, item.throttle}));
        p20   = 20'(item.pitch_term);
        r20   = 20'(item.roll_term);
        y20   = 20'(yaw_c);
        a20   = (item.mode == MODE_FIX_HEIGHT) ? 20'(item.altitude_term) : '0;
    end

    // Target selection per mode
    always_comb
    begin
        all_low = 1'b1;
        for (int i = 0; i < MOTORS; i++)
        begin
            target[i] = '0;
        end
        landed = 1'b0;
        unique case (item.mode)
            MODE_IDLE:
            begin
                for (int i = 0; i < MOTORS; i++)
                begin
                    target[i] = '0;
                end
            end
            MODE_NORMAL, MODE_FIX_HEIGHT:
            begin
                target[0] = sat_sum(thr20 + p20 - r20 + y20 + a20);
                target[1] = sat_sum(thr20 - p20 - r20 - y20 + a20);
                target[2] = sat_sum(thr20 + p20 + r20 - y20 + a20);
                target[3] = sat_sum(thr20 - p20 + r20 + y20 + a20);
            end
            MODE_FAULT:
            begin
                for (int i = 0; i < MOTORS; i++)
                begin
                    target[i] = $signed({6'b0, motor_speed[i]})
                              - $signed({10'b0, cfg.fault_step});
                    if (motor_speed[i] > {4'b0, cfg.fault_step})
                    begin
                        all_low = 1'b0;
                    end
                end
                landed = all_low;
            end
            default:
            begin
                // hold: aim at the present speed
                for (int i = 0; i < MOTORS; i++)
                begin
                    target[i] = $signed({6'b0, motor_speed[i]});
                end
            end
        endcase
    end

endmodule

[rtl/core/qmms_slew.sv]
// One motor: slew limit against the last value, speed clamp and throttle cut.
module qmms_slew (
    input  qmms_pkg::qmms_sum_t          target,
    input  qmms_pkg::qmms_sum_t          last,
    input  logic [9:0]                   slew_step,
    input  logic [qmms_pkg::SPEED_W-1:0] speed_max,
    input  logic                         cut,
    output qmms_pkg::qmms_sum_t          last_next,
    output logic [qmms_pkg::SPEED_W-1:0] speed
);
    import qmms_pkg::*;

    logic signed [18:0] diff;
    logic signed [18:0] step19;
    logic signed [18:0] slewed;
    qmms_sum_t          v;

    // Slew limit
    always_comb
    begin
        step19 = $signed({9'b0, slew_step});
        diff   = 19'(target) - 19'(last);
        if (diff > step19)
        begin
            slewed = 19'(last) + step19;
        end
        else if (diff < -step19)
        begin
            slewed = 19'(last) - step19;
        end
        else
        begin
            slewed = 19'(target);
        end
        v = sat_sum(20'(slewed));
    end

    // Clamp to 0..speed_max, then throttle cut
    always_comb
    begin
        if (cut)
        begin
            last_next = '0;
            speed     = '0;
        end
        else
        begin
            last_next = v;
            if (v < 0)
            begin
                speed = '0;
            end
            else if (v > $signed({6'b0, speed_max}))
            begin
                speed = speed_max;
            end
            else
            begin
                speed = v[SPEED_W-1:0];
            end
        end
    end

endmodule

[rtl/core/quad_motor_mixer_slew.sv]
// Top level of the quad motor mixer with per-motor slew limiting.
//
// Item channel (item_valid / item_stall / item): one control tick per transfer,
// carrying mode, throttle and the pitch, roll, yaw and altitude terms.
// Result channel (result_valid / result_stall / result): four motor speeds and
// the landed flag, exactly one result per item, in order.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
// always high; index 0 slew_step, 1 yaw_limit, 2 cut_throttle, 3 speed_max,
// 4 fault_step; other indexes are dropped. Write only while the block is idle.
// Path: an item taken is captured in the input register, and its result is
// loaded into the result register as soon as that register can advance.
// Throughput: one item per cycle unless result_stall holds; the mixer, slew and
// clamp logic between the input and result registers is combinational, and the
// per-motor state updates on the same edge that loads the result.
// Stall: while result_stall holds a result, the input register keeps its item
// and item_stall rises only if that register is full.
// Reset: config registers take their reset values, motor speeds and slew state go to
// zero, both channels are empty.
`include "assert_macros.svh"

module quad_motor_mixer_slew (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  qmms_pkg::qmms_item_t             item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output qmms_pkg::qmms_result_t           result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qmms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qmms_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import qmms_pkg::*;

    qmms_cfg_t          cfg_reg;
    qmms_cfg_t          cfg_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    qmms_item_t         s1_item_reg;
    qmms_item_t         s1_item_next;
    logic               result_valid_reg;
    logic               result_valid_next;
    qmms_result_t       result_reg;
    qmms_result_t       result_next;
    logic [SPEED_W-1:0] motor_speed_reg  [MOTORS];
    logic [SPEED_W-1:0] motor_speed_next [MOTORS];
    qmms_sum_t          slew_last_reg    [MOTORS];
    qmms_sum_t          slew_last_next   [MOTORS];

    qmms_sum_t          target    [MOTORS];
    qmms_sum_t          last_new  [MOTORS];
    logic [SPEED_W-1:0] speed_new [MOTORS];
    logic               landed;
    logic               cut;
    logic               advance;
    logic               fire;
    logic               accept;

    // Handshake
    assign cfg_ready    = 1'b1;
    assign advance      = !result_valid_reg || !result_stall;
    assign fire         = s1_valid_reg && advance;
    assign item_stall   = s1_valid_reg && !advance;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Config register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SLEW_STEP:    cfg_next.slew_step    = cfg_data[9:0];
                CFG_YAW_LIMIT:    cfg_next.yaw_limit    = cfg_data[11:0];
                CFG_CUT_THROTTLE: cfg_next.cut_throttle = cfg_data[9:0];
                CFG_SPEED_MAX:    cfg_next.speed_max    = cfg_data[11:0];
                CFG_FAULT_STEP:   cfg_next.fault_step   = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Datapath
    qmms_mixer u_mixer (
        .item        (s1_item_reg),
        .cfg         (cfg_reg),
        .motor_speed (motor_speed_reg),
        .target      (target),
        .landed      (landed)
    );

    assign cut = (s1_item_reg.throttle <= cfg_reg.cut_throttle);

    for (genvar g = 0; g < MOTORS; g++)
    begin : g_motor
        qmms_slew u_slew (
            .target    (target[g]),
            .last      (slew_last_reg[g]),
            .slew_step (cfg_reg.slew_step),
            .speed_max (cfg_reg.speed_max),
            .cut       (cut),
            .last_next (last_new[g]),
            .speed     (speed_new[g])
        );
    end

    // Pipeline and state next values
    always_comb
    begin
        s1_item_next = accept ? item : s1_item_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        result_valid_next = advance ? s1_valid_reg : result_valid_reg;

        result_next = result_reg;
        for (int i = 0; i < MOTORS; i++)
        begin
            motor_speed_next[i] = motor_speed_reg[i];
            slew_last_next[i]   = slew_last_reg[i];
        end
        if (fire)
        begin
            result_next.speed_front_left  = speed_new[0];
            result_next.speed_rear_left   = speed_new[1];
            result_next.speed_front_right = speed_new[2];
            result_next.speed_rear_right  = speed_new[3];
            result_next.landed_flag       = landed;
            for (int i = 0; i < MOTORS; i++)
            begin
                motor_speed_next[i] = speed_new[i];
                slew_last_next[i]   = last_new[i];
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slew_step    <= SLEW_STEP_RST;
            cfg_reg.yaw_limit    <= YAW_LIMIT_RST;
            cfg_reg.cut_throttle <= CUT_THROTTLE_RST;
            cfg_reg.speed_max    <= SPEED_MAX_RST;
            cfg_reg.fault_step   <= FAULT_STEP_RST;
            s1_valid_reg         <= 1'b0;
            result_valid_reg     <= 1'b0;
            for (int i = 0; i < MOTORS; i++)
            begin
                motor_speed_reg[i] <= '0;
                slew_last_reg[i]   <= '0;
            end
        end
        else
        begin
            cfg_reg          <= cfg_next;
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            for (int i = 0; i < MOTORS; i++)
            begin
                motor_speed_reg[i] <= motor_speed_next[i];
                slew_last_reg[i]   <= slew_last_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        result_reg  <= result_next;
    end

    // Assertions
    `ASSERT_CLK(a_stall_needs_item, item_stall |-> s1_valid_reg, "item_stall with empty input register")
    `ASSERT_CLK(a_fire_gives_result, fire |=> result_valid_reg, "processed item produced no result")
    `ASSERT_CLK(a_cut_clears_state, (fire && cut) |=> ((slew_last_reg[0] == '0) && (slew_last_reg[1] == '0) && (slew_last_reg[2] == '0) && (slew_last_reg[3] == '0)), "throttle cut left slew state")
    `ASSERT_CLK(a_result_held, (result_valid_reg && result_stall) |=> (result_valid_reg && $stable(result_reg)), "stalled result changed")

endmodule
